// ----- rtl/core/pps_pkg.sv -----
// Shared sizes, payload structs and cell-chain control types for the
// preemptive priority scheduler. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pps_pkg;

   localparam int MAX_TASKS     = 16;
   localparam int TIME_BITS     = 16;
   localparam int PRIORITY_BITS = 8;
   localparam int IDX_W         = $clog2(MAX_TASKS);
   localparam int CNT_W         = $clog2(MAX_TASKS + 1);

   localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

   localparam logic MODE_LOAD = 1'b0;
   localparam logic MODE_TICK = 1'b1;

   typedef struct packed {
      logic                     mode;
      logic [PRIORITY_BITS-1:0] priority_req;
      logic [TIME_BITS-1:0]     arrival;
      logic [TIME_BITS-1:0]     burst;
   } pps_req_type;

   typedef struct packed {
      logic [TIME_BITS-1:0] tick_time;
      logic                 ran;
      logic [IDX_W-1:0]     task_index;
      logic                 finished;
      logic [TIME_BITS-1:0] completion_time;
      logic [TIME_BITS-1:0] turnaround_time;
      logic [TIME_BITS-1:0] waiting_time;
      logic [TIME_BITS-1:0] response_time;
      logic                 all_done;
   } pps_rsp_type;

   // Best candidate so far, handed from cell to cell during a scan
   typedef struct packed {
      logic                     found;
      logic [PRIORITY_BITS-1:0] prio;
      logic [IDX_W-1:0]         index;
      logic [TIME_BITS-1:0]     arrival;
      logic [TIME_BITS-1:0]     burst;
      logic [TIME_BITS-1:0]     first_start;
      logic                     started;
      logic                     last_unit;
   } pps_cand_type;

   typedef struct packed {
      logic                     en;
      logic [IDX_W-1:0]         index;
      logic [PRIORITY_BITS-1:0] prio;
      logic [TIME_BITS-1:0]     arrival;
      logic [TIME_BITS-1:0]     burst;
   } pps_load_type;

   typedef struct packed {
      logic                 en;
      logic [IDX_W-1:0]     step;
      logic [TIME_BITS-1:0] now;
   } pps_scan_type;

   typedef struct packed {
      logic                 run;
      logic [IDX_W-1:0]     index;
      logic [TIME_BITS-1:0] now;
   } pps_upd_type;

endpackage

`default_nettype wire

// ----- rtl/core/pps_cell.sv -----
// One task slot of the scheduler chain: holds the task entry, merges it into
// the travelling best candidate on its scan step. Depends on pps_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pps_cell (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic [pps_pkg::IDX_W-1:0]   cell_idx,
   input  wire pps_pkg::pps_load_type       load,
   input  wire pps_pkg::pps_scan_type       scan,
   input  wire pps_pkg::pps_upd_type        upd,
   input  wire pps_pkg::pps_cand_type       cand_in,
   output pps_pkg::pps_cand_type            cand_out,
   output logic                             done_after
);

   logic                              loaded_ff, loaded_in;
   logic                              started_ff, started_in;
   logic                              finished_ff, finished_in;
   logic [pps_pkg::PRIORITY_BITS-1:0] prio_ff, prio_in;
   logic [pps_pkg::TIME_BITS-1:0]     arrival_ff, arrival_in;
   logic [pps_pkg::TIME_BITS-1:0]     burst_ff, burst_in;
   logic [pps_pkg::TIME_BITS-1:0]     remaining_ff, remaining_in;
   logic [pps_pkg::TIME_BITS-1:0]     first_start_ff, first_start_in;
   pps_pkg::pps_cand_type             best_ff, best_in;

   logic eligible;
   logic take;
   logic hit;
   logic last_unit;

   always_comb begin
      last_unit = (remaining_ff == pps_pkg::TIME_BITS'(1));
      eligible  = loaded_ff & ~finished_ff & (arrival_ff <= scan.now);
      take      = eligible & (~cand_in.found | (prio_ff < cand_in.prio));
      hit       = upd.run & (upd.index == cell_idx);

      best_in = best_ff;
      if (scan.en && scan.step == cell_idx) begin
         if (take) begin
            best_in.found       = 1'b1;
            best_in.prio        = prio_ff;
            best_in.index       = cell_idx;
            best_in.arrival     = arrival_ff;
            best_in.burst       = burst_ff;
            best_in.first_start = first_start_ff;
            best_in.started     = started_ff;
            best_in.last_unit   = last_unit;
         end else begin
            best_in = cand_in;
         end
      end

      loaded_in      = loaded_ff;
      started_in     = started_ff;
      finished_in    = finished_ff;
      prio_in        = prio_ff;
      arrival_in     = arrival_ff;
      burst_in       = burst_ff;
      remaining_in   = remaining_ff;
      first_start_in = first_start_ff;

      if (load.en && load.index == cell_idx) begin
         loaded_in      = 1'b1;
         started_in     = 1'b0;
         finished_in    = (load.burst == '0);
         prio_in        = load.prio;
         arrival_in     = load.arrival;
         burst_in       = load.burst;
         remaining_in   = load.burst;
         first_start_in = '0;
      end else if (hit) begin
         remaining_in = remaining_ff - pps_pkg::TIME_BITS'(1);
         if (!started_ff) begin
            started_in     = 1'b1;
            first_start_in = upd.now;
         end
         if (last_unit) begin
            finished_in = 1'b1;
         end
      end

      // state of this slot once the pending update has landed
      done_after = ~loaded_ff | finished_ff | (hit & last_unit);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         loaded_ff   <= 1'b0;
         started_ff  <= 1'b0;
         finished_ff <= 1'b0;
         best_ff     <= '0;
      end else begin
         loaded_ff   <= loaded_in;
         started_ff  <= started_in;
         finished_ff <= finished_in;
         best_ff     <= best_in;
      end
      prio_ff        <= prio_in;
      arrival_ff     <= arrival_in;
      burst_ff       <= burst_in;
      remaining_ff   <= remaining_in;
      first_start_ff <= first_start_in;
   end

   assign cand_out = best_ff;

endmodule

`default_nettype wire

// ----- rtl/core/preemptive_priority_scheduler.sv -----
// Preemptive priority scheduler top level: request decode, scan sequencing,
// timing figures and result register. Depends on pps_pkg and pps_cell.
//
// A load transaction fills the next free slot of a row of MAX_TASKS cells;
// loads past a full row are dropped. A tick transaction walks the best
// candidate through the cell row, one cell per cycle: an accept step,
// MAX_TASKS scan steps, and a report step that also retires the chosen
// task's time unit. The report step waits while a previous result is still
// held in the output register. Lowest priority value wins, lowest index on a
// tie; time saturates at its largest value.
`timescale 1ns / 1ps
`default_nettype none

module preemptive_priority_scheduler (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire pps_pkg::pps_req_type  req_data,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output pps_pkg::pps_rsp_type       rsp_data
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_REPORT
   } state_type;

   state_type                     state_ff, state_in;
   logic [pps_pkg::IDX_W-1:0]     step_ff, step_in;
   logic [pps_pkg::CNT_W-1:0]     count_ff, count_in;
   logic [pps_pkg::TIME_BITS-1:0] time_ff, time_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   pps_pkg::pps_rsp_type          rsp_ff, rsp_in;

   pps_pkg::pps_load_type         load;
   pps_pkg::pps_scan_type         scan;
   pps_pkg::pps_upd_type          upd;
   pps_pkg::pps_cand_type         chain [pps_pkg::MAX_TASKS];
   pps_pkg::pps_cand_type         best;
   logic [pps_pkg::MAX_TASKS-1:0] done_vec;

   logic                          req_take;
   logic                          out_free;
   logic                          report;
   logic [pps_pkg::TIME_BITS-1:0] comp;
   logic [pps_pkg::TIME_BITS-1:0] tat;
   logic [pps_pkg::TIME_BITS-1:0] fs;

   genvar gi;
   generate
      for (gi = 0; gi < pps_pkg::MAX_TASKS; gi++) begin : g_cell
         pps_pkg::pps_cand_type cand_prev;
         if (gi == 0) begin : g_head
            assign cand_prev = '0;
         end else begin : g_link
            assign cand_prev = chain[gi-1];
         end
         pps_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .cell_idx   (pps_pkg::IDX_W'(gi)),
            .load       (load),
            .scan       (scan),
            .upd        (upd),
            .cand_in    (cand_prev),
            .cand_out   (chain[gi]),
            .done_after (done_vec[gi])
         );
      end
   endgenerate

   assign best = chain[pps_pkg::MAX_TASKS-1];

   always_comb begin
      req_take = req_valid & (state_ff == ST_IDLE);
      out_free = ~rsp_valid_ff | ~rsp_stall;
      report   = (state_ff == ST_REPORT) & out_free;

      load.en      = req_take & (req_data.mode == pps_pkg::MODE_LOAD)
                     & (count_ff < pps_pkg::CNT_W'(pps_pkg::MAX_TASKS));
      load.index   = count_ff[pps_pkg::IDX_W-1:0];
      load.prio    = req_data.priority_req;
      load.arrival = req_data.arrival;
      load.burst   = req_data.burst;

      scan.en   = (state_ff == ST_SCAN);
      scan.step = step_ff;
      scan.now  = time_ff;

      upd.run   = report & best.found;
      upd.index = best.index;
      upd.now   = time_ff;

      comp = (time_ff != pps_pkg::TIME_MAX) ? time_ff + pps_pkg::TIME_BITS'(1)
                                            : pps_pkg::TIME_MAX;
      tat  = comp - best.arrival;
      fs   = best.started ? best.first_start : time_ff;

      state_in     = state_ff;
      step_in      = step_ff;
      count_in     = count_ff;
      time_in      = time_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      rsp_in       = rsp_ff;

      case (state_ff)
         ST_IDLE: begin
            if (load.en) begin
               count_in = count_ff + pps_pkg::CNT_W'(1);
            end
            if (req_take && req_data.mode == pps_pkg::MODE_TICK) begin
               step_in  = '0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            step_in = step_ff + pps_pkg::IDX_W'(1);
            if (step_ff == pps_pkg::IDX_W'(pps_pkg::MAX_TASKS - 1)) begin
               state_in = ST_REPORT;
            end
         end
         ST_REPORT: begin
            if (out_free) begin
               rsp_valid_in              = 1'b1;
               rsp_in.tick_time          = time_ff;
               rsp_in.ran                = best.found;
               rsp_in.task_index         = best.found ? best.index : '0;
               rsp_in.finished           = best.found & best.last_unit;
               rsp_in.completion_time    = '0;
               rsp_in.turnaround_time    = '0;
               rsp_in.waiting_time       = '0;
               rsp_in.response_time      = '0;
               if (best.found && best.last_unit) begin
                  rsp_in.completion_time = comp;
                  rsp_in.turnaround_time = tat;
                  rsp_in.waiting_time    = (tat >= best.burst) ? tat - best.burst : '0;
                  rsp_in.response_time   = fs - best.arrival;
               end
               rsp_in.all_done = &done_vec;
               if (time_ff != pps_pkg::TIME_MAX) begin
                  time_in = time_ff + pps_pkg::TIME_BITS'(1);
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         count_ff     <= '0;
         time_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         count_ff     <= count_in;
         time_ff      <= time_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

// ----- rtl/core/pps_checker.sv -----
// Port-level checks for the preemptive priority scheduler, bound to the top
// level. Depends on pps_pkg and preemptive_priority_scheduler.
`timescale 1ns / 1ps
`default_nettype none

module pps_checker (
   input wire logic                 clock,
   input wire logic                 reset,
   input wire logic                 req_valid,
   input wire logic                 req_stall,
   input wire pps_pkg::pps_req_type req_data,
   input wire logic                 rsp_valid,
   input wire logic                 rsp_stall,
   input wire pps_pkg::pps_rsp_type rsp_data
);

   // an idle tick names no task and finishes nothing
   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.ran) |->
         (rsp_data.task_index == '0 && !rsp_data.finished))
      else $error("idle tick reports a task");

   // a task finishing at a tick ends one unit later, or at the time ceiling
   a_completion: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.finished) |->
         (rsp_data.completion_time == rsp_data.tick_time + pps_pkg::TIME_BITS'(1) ||
          (rsp_data.tick_time == pps_pkg::TIME_MAX &&
           rsp_data.completion_time == pps_pkg::TIME_MAX)))
      else $error("completion time does not follow tick time");

   // timing figures stay zero unless the tick finished a task
   a_zero_unless_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.finished) |->
         (rsp_data.completion_time == '0 && rsp_data.turnaround_time == '0 &&
          rsp_data.waiting_time == '0 && rsp_data.response_time == '0))
      else $error("timing figures set on a tick that finished nothing");

   // a stalled result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_data)))
      else $error("stalled result transaction dropped or changed");

   // a stalled request stays offered
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_stall) |=> (req_valid && $stable(req_data)))
      else $error("stalled request transaction dropped or changed");

endmodule

bind preemptive_priority_scheduler pps_checker u_pps_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

`default_nettype wire
